FILE: rtl/mmlsu_pkg.sv
// ============================================================================
// mmlsu_pkg: shared types and constants of the load/store unit
// Opcodes, status codes, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ============================================================================
package mmlsu_pkg;

   // default sizes of the two stores
   localparam int DATA_BYTES_DEF    = 65536;
   localparam int PROGRAM_WORDS_DEF = 16384;

   // opcodes
   localparam logic [3:0] OP_LB  = 4'd0;
   localparam logic [3:0] OP_LBU = 4'd1;
   localparam logic [3:0] OP_LH  = 4'd2;
   localparam logic [3:0] OP_LHU = 4'd3;
   localparam logic [3:0] OP_LW  = 4'd4;
   localparam logic [3:0] OP_LWL = 4'd5;
   localparam logic [3:0] OP_LWR = 4'd6;
   localparam logic [3:0] OP_SB  = 4'd7;
   localparam logic [3:0] OP_SH  = 4'd8;
   localparam logic [3:0] OP_SW  = 4'd9;
   localparam logic [3:0] OP_PW  = 4'd10;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_MISALIGN = 2'd1;
   localparam logic [1:0] STAT_RANGE    = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_PROGRAM_BASE = 2'd0;
   localparam logic [1:0] CSR_DATA_BASE    = 2'd1;
   localparam logic [1:0] CSR_INPUT_PORT   = 2'd2;
   localparam logic [1:0] CSR_OUTPUT_PORT  = 2'd3;

   // register reset values
   localparam logic [31:0] PROGRAM_BASE_RST = 32'h1000_0000;
   localparam logic [31:0] DATA_BASE_RST    = 32'h2000_0000;
   localparam logic [31:0] INPUT_PORT_RST   = 32'h3000_0000;
   localparam logic [31:0] OUTPUT_PORT_RST  = 32'h3000_0004;

   // byte masks for partial-word merges
   localparam logic [31:0] MASK_B3  = 32'hFF00_0000;
   localparam logic [31:0] MASK_B2  = 32'h00FF_0000;
   localparam logic [31:0] MASK_B1  = 32'h0000_FF00;
   localparam logic [31:0] MASK_B0  = 32'h0000_00FF;
   localparam logic [31:0] MASK_HI  = 32'hFFFF_0000;
   localparam logic [31:0] MASK_LO  = 32'h0000_FFFF;
   localparam logic [31:0] MASK_LO3 = 32'h00FF_FFFF;
   localparam logic [31:0] MASK_HI3 = 32'hFFFF_FF00;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_OFS,
      ST_DECIDE,
      ST_DRD,
      ST_DRDW,
      ST_PRD,
      ST_PRDW,
      ST_DWR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0] status;
      logic       load;
      logic       cons;
      logic       cout;
   } outcome_type;

   typedef struct packed {
      logic        take;
      logic        calc_ea;
      logic        calc_ofs;
      logic        lane_init;
      logic        lane_next;
      logic        lane_capture;
      logic        prog_capture;
      logic        port_capture;
      logic        data_we;
      logic        prog_we;
      logic        clear;
      logic        finish;
      outcome_type res;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic misalign;
      logic is_load;
      logic is_store;
      logic is_prog_wr;
      logic data_hit;
      logic lanes_ok;
      logic prog_hit;
      logic in_hit;
      logic out_hit;
      logic lane_last;
      logic out_free;
   } stat_type;

endpackage

FILE: rtl/mmlsu_ram.sv
// ============================================================================
// mmlsu_ram: generic single-port RAM
// One address per cycle; read every cycle, written when wr_en is set; read data registered.
// ============================================================================
module mmlsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry when enabled, read the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mmlsu_ctrl.sv
// ============================================================================
// mmlsu_ctrl: controller of the load/store unit
// Sequences clearing, address calculation, region decision, byte lanes
// and result hand-off.
// ============================================================================
module mmlsu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mmlsu_pkg::stat_type stat,
   output mmlsu_pkg::cmd_type  cmd
);
   import mmlsu_pkg::*;

   state_type   state_ff, state_in;
   outcome_type outcome_ff, outcome_in;

   // advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         outcome_ff <= '0;
      end else begin
         state_ff   <= state_in;
         outcome_ff <= outcome_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (stat.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_OFS;
         ST_OFS:    state_in = ST_DECIDE;
         ST_DECIDE: begin
            state_in = ST_FINISH;
            if (!stat.misalign) begin
               if (stat.is_load) begin
                  if (stat.data_hit) begin
                     if (stat.lanes_ok) state_in = ST_DRD;
                  end else if (stat.prog_hit) begin
                     state_in = ST_PRD;
                  end
               end else if (stat.is_store) begin
                  if (stat.data_hit && stat.lanes_ok) state_in = ST_DWR;
               end
            end
         end
         ST_DRD:    state_in = ST_DRDW;
         ST_DRDW:   state_in = stat.lane_last ? ST_FINISH : ST_DRD;
         ST_PRD:    state_in = ST_PRDW;
         ST_PRDW:   state_in = ST_FINISH;
         ST_DWR:    if (stat.lane_last) state_in = ST_FINISH;
         ST_FINISH: if (stat.out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // settle the outcome of the access
   always_comb begin
      outcome_in = outcome_ff;
      if (state_ff == ST_DECIDE) begin
         outcome_in = '0;
         if (stat.misalign) begin
            outcome_in.status = STAT_MISALIGN;
         end else if (stat.is_load) begin
            if (stat.data_hit) begin
               if (stat.lanes_ok) outcome_in.load = 1'b1;
               else outcome_in.status = STAT_RANGE;
            end else if (stat.prog_hit) begin
               outcome_in.load = 1'b1;
            end else if (stat.in_hit) begin
               outcome_in.load = 1'b1;
               outcome_in.cons = 1'b1;
            end else begin
               outcome_in.status = STAT_RANGE;
            end
         end else if (stat.is_store) begin
            if (stat.data_hit) begin
               if (!stat.lanes_ok) outcome_in.status = STAT_RANGE;
            end else if (stat.out_hit) begin
               outcome_in.cout = 1'b1;
            end else begin
               outcome_in.status = STAT_RANGE;
            end
         end else if (stat.is_prog_wr) begin
            if (!stat.prog_hit) outcome_in.status = STAT_RANGE;
         end
      end
   end

   // drive commands
   always_comb begin
      cmd     = '0;
      cmd.res = outcome_ff;
      case (state_ff)
         ST_CLEAR:  cmd.clear = 1'b1;
         ST_IDLE:   cmd.take = 1'b1;
         ST_ADDR:   cmd.calc_ea = 1'b1;
         ST_OFS:    cmd.calc_ofs = 1'b1;
         ST_DECIDE: begin
            cmd.lane_init    = 1'b1;
            cmd.port_capture = 1'b1;
            cmd.prog_we      = !stat.misalign && stat.is_prog_wr && stat.prog_hit;
         end
         ST_DRD:    cmd.lane_init = 1'b0;
         ST_DRDW: begin
            cmd.lane_capture = 1'b1;
            cmd.lane_next    = 1'b1;
         end
         ST_PRD:    cmd.lane_init = 1'b0;
         ST_PRDW:   cmd.prog_capture = 1'b1;
         ST_DWR: begin
            cmd.data_we   = 1'b1;
            cmd.lane_next = 1'b1;
         end
         ST_FINISH: cmd.finish = stat.out_free;
         default:   cmd.clear = 1'b0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

FILE: rtl/mmlsu_dpath.sv
// ============================================================================
// mmlsu_dpath: datapath of the load/store unit
// Holds registers, item and address registers, the two stores, the byte
// lane assembly and the result register.
// ============================================================================
module mmlsu_dpath #(
   parameter int DATA_BYTES    = mmlsu_pkg::DATA_BYTES_DEF,
   parameter int PROGRAM_WORDS = mmlsu_pkg::PROGRAM_WORDS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wr_data,
   input  logic                req_valid,
   input  logic [3:0]          req_opcode,
   input  logic signed [31:0]  req_base_value,
   input  logic signed [15:0]  req_offset_value,
   input  logic signed [31:0]  req_reg_value,
   input  logic signed [8:0]   req_port_char,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_load_value,
   output logic                rsp_writeback,
   output logic                rsp_char_consumed,
   output logic                rsp_char_out_valid,
   output logic [7:0]          rsp_char_out,
   output logic [1:0]          rsp_status,
   input  mmlsu_pkg::cmd_type  cmd,
   output mmlsu_pkg::stat_type stat
);
   import mmlsu_pkg::*;

   localparam int DAW   = $clog2(DATA_BYTES);
   localparam int PAW   = (PROGRAM_WORDS > 1) ? $clog2(PROGRAM_WORDS) : 1;
   localparam int CLR_N = (DATA_BYTES > PROGRAM_WORDS) ? DATA_BYTES : PROGRAM_WORDS;
   localparam int CLW   = $clog2(CLR_N);
   localparam logic [32:0] DATA_LIM = 33'(DATA_BYTES);
   localparam logic [32:0] PROG_LIM = 33'(PROGRAM_WORDS) * 33'd4;

   // configuration registers
   logic [31:0] pbase_ff, dbase_ff, inport_ff, outport_ff;
   // item registers
   logic [3:0]  op_ff;
   logic [31:0] base_ff, rv_ff;
   logic [15:0] off_ff;
   logic [8:0]  pc_ff;
   // address registers
   logic [31:0] ea_ff, dofs_ff, pofs_ff;
   logic        in_hit_ff, out_hit_ff;
   // lane assembly
   logic [1:0]  lane_ff;
   logic [31:0] word_ff;
   logic [CLW-1:0] clr_ff;
   // result register
   logic        rsp_valid_ff;
   logic [31:0] load_ff;
   logic        wb_ff, cons_ff, cv_ff;
   logic [7:0]  ch_ff;
   logic [1:0]  st_ff;

   logic [1:0]  k;
   logic [1:0]  lo, hi;
   logic [3:0]  lane_hit;
   logic [31:0] lane_ofs;
   logic [31:0] sw_word;
   logic [7:0]  b_val, d_rd, d_wr;
   logic [15:0] h_val;
   logic [31:0] val, p_rd;
   logic [7:0]  ch;
   logic [DAW-1:0] d_addr;
   logic [PAW-1:0] p_addr;
   logic        d_we, p_we;
   logic [31:0] p_wr;

   assign k = ea_ff[1:0];

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pbase_ff   <= PROGRAM_BASE_RST;
         dbase_ff   <= DATA_BASE_RST;
         inport_ff  <= INPUT_PORT_RST;
         outport_ff <= OUTPUT_PORT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PROGRAM_BASE: pbase_ff   <= csr_wr_data;
            CSR_DATA_BASE:    dbase_ff   <= csr_wr_data;
            CSR_INPUT_PORT:   inport_ff  <= csr_wr_data;
            CSR_OUTPUT_PORT:  outport_ff <= csr_wr_data;
            default:          pbase_ff   <= pbase_ff;
         endcase
      end
   end

   // capture the item and work out addresses
   always_ff @(posedge clock) begin
      if (cmd.take && req_valid) begin
         op_ff   <= req_opcode;
         base_ff <= req_base_value;
         off_ff  <= req_offset_value;
         rv_ff   <= req_reg_value;
         pc_ff   <= req_port_char;
      end
      if (cmd.calc_ea) begin
         ea_ff <= base_ff + {{16{off_ff[15]}}, off_ff};
      end
      if (cmd.calc_ofs) begin
         dofs_ff    <= ea_ff - dbase_ff;
         pofs_ff    <= ea_ff - {pbase_ff[31:2], 2'b00};
         in_hit_ff  <= (ea_ff[31:2] == inport_ff[31:2]);
         out_hit_ff <= (ea_ff[31:2] == outport_ff[31:2]);
      end
   end

   // lane range of the access
   always_comb begin
      lo = k;
      hi = k;
      case (op_ff)
         OP_LB, OP_LBU, OP_SB: begin lo = k; hi = k; end
         OP_LH, OP_LHU, OP_SH: begin lo = k; hi = k + 2'd1; end
         OP_LWL:               begin lo = k; hi = 2'd3; end
         OP_LWR:               begin lo = 2'd0; hi = k; end
         default:              begin lo = 2'd0; hi = 2'd3; end
      endcase
   end

   // check every touched byte against the data region
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         lane_hit[l] = (2'(l) < lo) || (2'(l) > hi) ||
            ({1'b0, dofs_ff - {30'd0, k} + 32'(l)} < DATA_LIM);
      end
   end

   always_comb begin
      stat.clear_done = (clr_ff == CLW'(CLR_N - 1));
      stat.misalign   = (((op_ff == OP_LH) || (op_ff == OP_LHU) || (op_ff == OP_SH))
                         && ea_ff[0]) ||
                        (((op_ff == OP_LW) || (op_ff == OP_SW) || (op_ff == OP_PW))
                         && (k != 2'd0));
      stat.is_load    = (op_ff <= OP_LWR);
      stat.is_store   = (op_ff >= OP_SB) && (op_ff <= OP_SW);
      stat.is_prog_wr = (op_ff == OP_PW);
      stat.data_hit   = ({1'b0, dofs_ff} < DATA_LIM);
      stat.lanes_ok   = &lane_hit;
      stat.prog_hit   = ({1'b0, pofs_ff} < PROG_LIM);
      stat.in_hit     = in_hit_ff;
      stat.out_hit    = out_hit_ff;
      stat.lane_last  = (lane_ff == hi);
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // store data placed on its big-endian lanes
   always_comb begin
      case (op_ff)
         OP_SB:   sw_word = {24'd0, rv_ff[7:0]} << {(2'd3 - k), 3'b000};
         OP_SH:   sw_word = k[1] ? {16'd0, rv_ff[15:0]} : {rv_ff[15:0], 16'd0};
         default: sw_word = rv_ff;
      endcase
   end

   assign lane_ofs = dofs_ff - {30'd0, k} + {30'd0, lane_ff};
   assign d_wr     = 8'(sw_word >> {(2'd3 - lane_ff), 3'b000});

   // memory ports: clearing sweep or normal access
   always_comb begin
      if (cmd.clear) begin
         d_we   = ({{(32-CLW){1'b0}}, clr_ff} < 32'(DATA_BYTES));
         d_addr = DAW'(clr_ff);
         p_we   = ({{(32-CLW){1'b0}}, clr_ff} < 32'(PROGRAM_WORDS));
         p_addr = PAW'(clr_ff);
         p_wr   = '0;
      end else begin
         d_we   = cmd.data_we;
         d_addr = lane_ofs[DAW-1:0];
         p_we   = cmd.prog_we;
         p_addr = pofs_ff[PAW+1:2];
         p_wr   = rv_ff;
      end
   end

   mmlsu_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_data_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .addr    (d_addr),
      .wr_data (cmd.clear ? 8'd0 : d_wr),
      .rd_data (d_rd)
   );

   mmlsu_ram #(.WIDTH(32), .DEPTH(PROGRAM_WORDS)) u_prog_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .addr    (p_addr),
      .wr_data (p_wr),
      .rd_data (p_rd)
   );

   // sweep the clear counter, step lanes, assemble the loaded word
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear && !stat.clear_done) begin
         clr_ff <= clr_ff + CLW'(1);
      end
      if (cmd.lane_init) begin
         lane_ff <= lo;
      end else if (cmd.lane_next) begin
         lane_ff <= lane_ff + 2'd1;
      end
      // seed with the input port word, then fill data lanes or the program word
      if (cmd.port_capture) begin
         word_ff <= {{23{pc_ff[8]}}, pc_ff};
      end else if (cmd.lane_capture) begin
         word_ff[{(2'd3 - lane_ff), 3'b000} +: 8] <= d_rd;
      end else if (cmd.prog_capture) begin
         word_ff <= p_rd;
      end
   end

   // extract the load value
   assign b_val = 8'(word_ff >> {(2'd3 - k), 3'b000});
   assign h_val = k[1] ? word_ff[15:0] : word_ff[31:16];

   always_comb begin
      case (op_ff)
         OP_LB:   val = {{24{b_val[7]}}, b_val};
         OP_LBU:  val = {24'd0, b_val};
         OP_LH:   val = {{16{h_val[15]}}, h_val};
         OP_LHU:  val = {16'd0, h_val};
         OP_LWL: begin
            case (k)
               2'd1:    val = {word_ff[23:0], 8'd0}  | (rv_ff & MASK_B0);
               2'd2:    val = {word_ff[15:0], 16'd0} | (rv_ff & MASK_LO);
               2'd3:    val = {word_ff[7:0], 24'd0}  | (rv_ff & MASK_LO3);
               default: val = word_ff;
            endcase
         end
         OP_LWR: begin
            case (k)
               2'd0:    val = {24'd0, word_ff[31:24]} | (rv_ff & MASK_HI3);
               2'd1:    val = {16'd0, word_ff[31:16]} | (rv_ff & MASK_HI);
               2'd2:    val = {8'd0, word_ff[31:8]}   | (rv_ff & MASK_B3);
               default: val = word_ff;
            endcase
         end
         default: val = word_ff;
      endcase
   end

   // character sent to the output port
   always_comb begin
      case (op_ff)
         OP_SB:   ch = (k == 2'd3) ? rv_ff[7:0] : 8'd0;
         OP_SH:   ch = (k == 2'd0) ? rv_ff[23:16] : rv_ff[7:0];
         default: ch = rv_ff[7:0];
      endcase
   end

   // hold the result until the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         load_ff <= cmd.res.load ? val : 32'd0;
         wb_ff   <= cmd.res.load;
         cons_ff <= cmd.res.cons;
         cv_ff   <= cmd.res.cout;
         ch_ff   <= cmd.res.cout ? ch : 8'd0;
         st_ff   <= cmd.res.status;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_load_value     = load_ff;
   assign rsp_writeback      = wb_ff;
   assign rsp_char_consumed  = cons_ff;
   assign rsp_char_out_valid = cv_ff;
   assign rsp_char_out       = ch_ff;
   assign rsp_status         = st_ff;

endmodule

FILE: rtl/memory_mapped_load_store_unit.sv
// ============================================================================
// memory_mapped_load_store_unit: big-endian load/store unit
// Byte data store, word program store and two character ports.
// ============================================================================
// After reset the unit sweeps both stores to zero, one entry per cycle, over
// max(DATA_BYTES, PROGRAM_WORDS) entries, taking no request meanwhile
// (register writes are taken). One request is then worked at a time: the
// accept state, effective address, region offsets and region decision, then
// for a data store access a read and a capture state for each byte lane
// (loads) or a write state for each lane (stores), a read and a capture state
// for a program store read, and a finish state that hands the result to the
// output register once it is free. The single-port byte RAM of the data
// store makes data store accesses go one lane at a time. The next request is
// taken while a result still waits on rsp_stall.
module memory_mapped_load_store_unit #(
   parameter int DATA_BYTES    = mmlsu_pkg::DATA_BYTES_DEF,
   parameter int PROGRAM_WORDS = mmlsu_pkg::PROGRAM_WORDS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_base_value,
   input  logic signed [15:0] req_offset_value,
   input  logic signed [31:0] req_reg_value,
   input  logic signed [8:0]  req_port_char,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_load_value,
   output logic               rsp_writeback,
   output logic               rsp_char_consumed,
   output logic               rsp_char_out_valid,
   output logic [7:0]         rsp_char_out,
   output logic [1:0]         rsp_status
);
   import mmlsu_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mmlsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mmlsu_dpath #(
      .DATA_BYTES    (DATA_BYTES),
      .PROGRAM_WORDS (PROGRAM_WORDS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_opcode         (req_opcode),
      .req_base_value     (req_base_value),
      .req_offset_value   (req_offset_value),
      .req_reg_value      (req_reg_value),
      .req_port_char      (req_port_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_load_value     (rsp_load_value),
      .rsp_writeback      (rsp_writeback),
      .rsp_char_consumed  (rsp_char_consumed),
      .rsp_char_out_valid (rsp_char_out_valid),
      .rsp_char_out       (rsp_char_out),
      .rsp_status         (rsp_status),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule
